[rtl/jsu_pkg.sv]
`timescale 1ns / 1ps
// jsu_pkg: shared types, codes and helpers for the json string unescaper
// no dependencies; imported by the front, queue, back and top modules

package jsu_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  // result kind codes
  typedef enum logic [1:0] {
    K_BYTE  = 2'd0,
    K_DONE  = 2'd1,
    K_MALF  = 2'd2,
    K_TRUNC = 2'd3
  } kind_t;

  // source characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // one queued command: up to three results of one kind
  typedef struct packed {
    logic [1:0] cnt;
    kind_t      kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // hex digit decode: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

[rtl/jsu_feed_if.sv]
`timescale 1ns / 1ps
// jsu_feed_if: source byte channel of the json string unescaper
// no dependencies

interface jsu_feed_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[rtl/jsu_result_if.sv]
`timescale 1ns / 1ps
// jsu_result_if: decoded result channel of the json string unescaper
// no dependencies

interface jsu_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

[rtl/json_string_unescape_top.sv]
`timescale 1ns / 1ps
// json_string_unescape_top: json string unescaper with utf-8 output
// depends on jsu_pkg, jsu_feed_if, jsu_result_if, jsu_front, jsu_queue, jsu_back
//
// channel | dir | payload                  | handshake
// feed    | in  | in_byte[7:0]             | valid/ready
// result  | out | out_byte[7:0] kind[1:0] last | valid/ready
//
// the front takes one byte per cycle while the command queue has room
// a byte gives 0 to 3 results; the back sends one result request per cycle
// while the receiver is ready; a \u escape giving n utf-8 bytes sends n results,
// the queue of QDEPTH commands absorbs the difference
// reset is synchronous and clears the parser state and queue
// either side may stall at any time without loss

module json_string_unescape_top
  import jsu_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  jsu_feed_if.sink     feed,
  jsu_result_if.source result
);

  q_stat_t q_stat;
  logic    q_push, q_pop;
  cmd_t    q_wr, q_head;

  // front: accept and classify
  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .q_stat (q_stat),
    .push   (q_push),
    .cmd    (q_wr)
  );

  // command queue
  jsu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (q_wr),
    .pop    (q_pop),
    .rd_cmd (q_head),
    .stat   (q_stat)
  );

  // back: emit results
  jsu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (q_pop),
    .result (result)
  );

  // no command is written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // end and error results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind != K_BYTE) |-> result.out_byte == 8'd0)
    else $error("non-byte result with nonzero byte");

  // end and error results are always the final result of their byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind != K_BYTE) |-> result.last)
    else $error("non-byte result without last");

endmodule

[rtl/jsu_front.sv]
`timescale 1ns / 1ps
// jsu_front: accepts source bytes, tracks escapes and builds result commands
// depends on jsu_pkg and jsu_feed_if

module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  jsu_feed_if.sink   feed,
  input  q_stat_t    q_stat,
  output logic       push,
  output cmd_t       cmd
);

  phase_t      phase, phase_next;
  logic [15:0] code_acc, code_acc_next;
  logic [1:0]  hex_seen, hex_seen_next;

  logic        fire;
  logic [7:0]  c;
  logic [4:0]  hex;
  logic [15:0] code;

  assign feed.ready = !q_stat.full;
  assign fire       = feed.valid && feed.ready;
  assign c          = feed.in_byte;
  assign hex        = hex_decode(c);
  assign code       = {code_acc[11:0], hex[3:0]};

  // classify the byte and work out the command and next state
  always_comb begin
    phase_next    = phase;
    code_acc_next = code_acc;
    hex_seen_next = hex_seen;
    cmd           = '{cnt: 2'd0, kind: K_BYTE, b0: 8'd0, b1: 8'd0, b2: 8'd0};
    unique case (phase)
      PH_WAIT: begin
        if (c == CH_QUOTE) begin
          phase_next = PH_BODY;
        end else begin
          cmd.cnt  = 2'd1;
          cmd.kind = K_MALF;
        end
      end
      PH_BODY: begin
        priority if (c == CH_NUL) begin
          phase_next = PH_WAIT;
          cmd.cnt    = 2'd1;
          cmd.kind   = K_TRUNC;
        end else if (c == CH_QUOTE) begin
          phase_next = PH_WAIT;
          cmd.cnt    = 2'd1;
          cmd.kind   = K_DONE;
        end else if (c == CH_BSL) begin
          phase_next = PH_ESC;
        end else begin
          cmd.cnt = 2'd1;
          cmd.b0  = c;
        end
      end
      PH_ESC: begin
        phase_next = PH_BODY;
        cmd.cnt    = 2'd1;
        unique case (c)
          CH_QUOTE, CH_BSL, CH_SLASH: cmd.b0 = c;
          CH_B: cmd.b0 = 8'h08;
          CH_F: cmd.b0 = 8'h0C;
          CH_N: cmd.b0 = 8'h0A;
          CH_R: cmd.b0 = 8'h0D;
          CH_T: cmd.b0 = 8'h09;
          CH_U: begin
            phase_next    = PH_HEX;
            code_acc_next = 16'd0;
            hex_seen_next = 2'd0;
            cmd.cnt       = 2'd0;
          end
          default: begin
            phase_next = PH_WAIT;
            cmd.kind   = K_MALF;
          end
        endcase
      end
      PH_HEX: begin
        priority if (!hex[4]) begin
          phase_next    = PH_WAIT;
          code_acc_next = 16'd0;
          hex_seen_next = 2'd0;
          cmd.cnt       = 2'd1;
          cmd.kind      = K_MALF;
        end else if (hex_seen != 2'd3) begin
          code_acc_next = code;
          hex_seen_next = hex_seen + 2'd1;
        end else begin
          // fourth digit: encode the code point as utf-8 or reject a surrogate
          code_acc_next = 16'd0;
          hex_seen_next = 2'd0;
          phase_next    = PH_BODY;
          priority if (code[15:7] == 9'd0) begin
            cmd.cnt = 2'd1;
            cmd.b0  = code[7:0];
          end else if (code[15:11] == 5'd0) begin
            cmd.cnt = 2'd2;
            cmd.b0  = {3'b110, code[10:6]};
            cmd.b1  = {2'b10, code[5:0]};
          end else if (code[15:11] == 5'b11011) begin
            // surrogate range is rejected
            phase_next = PH_WAIT;
            cmd.cnt    = 2'd1;
            cmd.kind   = K_MALF;
          end else begin
            cmd.cnt = 2'd3;
            cmd.b0  = {4'b1110, code[15:12]};
            cmd.b1  = {2'b10, code[11:6]};
            cmd.b2  = {2'b10, code[5:0]};
          end
        end
      end
      default: phase_next = PH_WAIT;
    endcase
  end

  assign push = fire && (cmd.cnt != 2'd0);

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_WAIT;
      code_acc <= 16'd0;
      hex_seen <= 2'd0;
    end else if (fire) begin
      phase    <= phase_next;
      code_acc <= code_acc_next;
      hex_seen <= hex_seen_next;
    end
  end

endmodule

[rtl/jsu_queue.sv]
`timescale 1ns / 1ps
// jsu_queue: small command queue between front and back
// depends on jsu_pkg

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    wr_cmd,
  input  logic    pop,
  output cmd_t    rd_cmd,
  output q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_cmd     = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/jsu_back.sv]
`timescale 1ns / 1ps
// jsu_back: expands queued commands into one result request per cycle
// while result.ready is high; depends on jsu_pkg and jsu_result_if

module jsu_back
  import jsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         head,
  input  q_stat_t      q_stat,
  output logic         pop,
  jsu_result_if.source result
);

  logic [1:0] sel, sel_next;
  logic       is_last;
  logic       fire;

  assign is_last = (sel == (head.cnt - 2'd1));
  assign fire    = result.valid && result.ready;
  assign pop     = fire && is_last;

  // drive the current result of the head command
  always_comb begin
    result.valid = !q_stat.empty;
    result.kind  = head.kind;
    result.last  = is_last;
    unique case (sel)
      2'd0:    result.out_byte = head.b0;
      2'd1:    result.out_byte = head.b1;
      2'd2:    result.out_byte = head.b2;
      default: result.out_byte = 8'd0;
    endcase
    sel_next = is_last ? 2'd0 : sel + 2'd1;
  end

  // result index within the head command
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 2'd0;
    end else if (fire) begin
      sel <= sel_next;
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for json_string_unescape_top, quoted source bytes in, decoded bytes out
// depends on jsu_pkg, jsu_feed_if, jsu_result_if and the unescaper rtl

module tb;
  import jsu_pkg::*;

  localparam int BY_MODEL    = -1;     // row result comes from the decoder model
  localparam int HOLD_CYCLES = 150;    // long receiver hold-off
  localparam int TAIL_CYCLES = 12;     // settle time once nothing is pending
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 85;

  localparam logic [15:0] ONE_BYTE_END = 16'h0080;
  localparam logic [15:0] TWO_BYTE_END = 16'h0800;
  localparam logic [15:0] SURR_LO      = 16'hD800;
  localparam logic [15:0] SURR_HI      = 16'hDFFF;
  localparam logic [7:0]  LEAD2        = 8'hC0;
  localparam logic [7:0]  LEAD3        = 8'hE0;
  localparam logic [7:0]  CONT         = 8'h80;
  localparam logic [5:0]  CONT_MASK    = 6'h3F;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       last;
  } result_t;

  // one source byte with an optional hand-written result
  typedef struct {
    logic [7:0] in_byte;
    int         fixed_n;
    kind_t      kind;
    logic [7:0] out_byte;
  } src_row_t;

  logic clk = 1'b0;
  logic rst;

  jsu_feed_if   feed ();
  jsu_result_if result ();

  json_string_unescape_top u_dut (
    .clk   (clk),
    .rst   (rst),
    .feed  (feed),
    .result(result)
  );

  // decoder state mirrored from the block
  phase_t      dec_phase;
  logic [15:0] dec_code;
  logic [1:0]  dec_hex;
  result_t     step_res [0:2];
  result_t     pending_results [$];

  src_row_t offer;
  int       src_idle_pct;
  int       snk_stall_pct;
  int       hold_left = 0;
  bit       hold_pending;
  int       err_cnt;
  int       bytes_sent;
  int       strings_sent;
  int       results_seen;
  int       cycle_cnt;

  // directed walk: extremes, \u0000, three-byte escape, surrogate, errors
  src_row_t directed_rows [] = '{
    '{CH_NUL,   1, K_MALF,  8'h00},
    '{8'hFF,    1, K_MALF,  8'h00},
    '{CH_QUOTE, 0, K_BYTE,  8'h00},
    '{8'hFF,    1, K_BYTE,  8'hFF},
    '{CH_BSL,   0, K_BYTE,  8'h00},
    '{CH_U,     0, K_BYTE,  8'h00},
    '{"0",      0, K_BYTE,  8'h00},
    '{"0",      0, K_BYTE,  8'h00},
    '{"0",      0, K_BYTE,  8'h00},
    '{"0",      1, K_BYTE,  8'h00},
    '{CH_BSL,   0, K_BYTE,  8'h00},
    '{CH_U,     0, K_BYTE,  8'h00},
    '{"F",      0, K_BYTE,  8'h00},
    '{"f",      0, K_BYTE,  8'h00},
    '{"f",      0, K_BYTE,  8'h00},
    '{"F",      BY_MODEL, K_BYTE, 8'h00},
    '{CH_BSL,   0, K_BYTE,  8'h00},
    '{CH_U,     0, K_BYTE,  8'h00},
    '{"d",      0, K_BYTE,  8'h00},
    '{"8",      0, K_BYTE,  8'h00},
    '{"0",      0, K_BYTE,  8'h00},
    '{"0",      1, K_MALF,  8'h00},
    '{CH_QUOTE, 0, K_BYTE,  8'h00},
    '{CH_QUOTE, 1, K_DONE,  8'h00},
    '{CH_QUOTE, 0, K_BYTE,  8'h00},
    '{CH_NUL,   1, K_TRUNC, 8'h00},
    '{CH_QUOTE, 0, K_BYTE,  8'h00},
    '{CH_BSL,   0, K_BYTE,  8'h00},
    '{CH_NUL,   1, K_MALF,  8'h00}
  };

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("[json_string_unescape_top] ERROR");
      $finish;
    end
  end

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void put_result(input int k, input logic [7:0] b, input kind_t kd);
    step_res[k] = '{out_byte: b, kind: kd, last: 1'b0};
  endfunction

  function automatic int drop_string(input kind_t kd);
    dec_phase = PH_WAIT;
    dec_code  = '0;
    dec_hex   = '0;
    put_result(0, 8'h00, kd);
    return 1;
  endfunction

  // decode one source byte, leaving its results in step_res
  function automatic int unescape_byte(input logic [7:0] c);
    int          n;
    int          d;
    logic [15:0] cp;
    logic [7:0]  v;
    n = 0;
    case (dec_phase)
      PH_WAIT: begin
        if (c == CH_QUOTE) dec_phase = PH_BODY;
        else n = drop_string(K_MALF);
      end
      PH_BODY: begin
        if (c == CH_NUL) begin
          n = drop_string(K_TRUNC);
        end else if (c == CH_QUOTE) begin
          dec_phase = PH_WAIT;
          put_result(0, 8'h00, K_DONE);
          n = 1;
        end else if (c == CH_BSL) begin
          dec_phase = PH_ESC;
        end else begin
          put_result(0, c, K_BYTE);
          n = 1;
        end
      end
      PH_ESC: begin
        v = c;
        case (c)
          CH_QUOTE, CH_BSL, CH_SLASH: v = c;
          CH_B: v = 8'h08;
          CH_F: v = 8'h0C;
          CH_N: v = 8'h0A;
          CH_R: v = 8'h0D;
          CH_T: v = 8'h09;
          CH_U: begin
            dec_phase = PH_HEX;
            dec_code  = '0;
            dec_hex   = '0;
            n = -1;
          end
          default: n = drop_string(K_MALF);
        endcase
        if (n == 0) begin
          dec_phase = PH_BODY;
          put_result(0, v, K_BYTE);
          n = 1;
        end else if (n < 0) begin
          n = 0;
        end
      end
      default: begin
        d = hex_nibble(c);
        if (d < 0) begin
          n = drop_string(K_MALF);
        end else begin
          cp = {dec_code[11:0], 4'(d)};
          if (dec_hex != 2'd3) begin
            dec_code = cp;
            dec_hex  = dec_hex + 2'd1;
          end else begin
            dec_code = '0;
            dec_hex  = '0;
            if (cp < ONE_BYTE_END) begin
              dec_phase = PH_BODY;
              put_result(0, cp[7:0], K_BYTE);
              n = 1;
            end else if (cp < TWO_BYTE_END) begin
              dec_phase = PH_BODY;
              put_result(0, LEAD2 | 8'(cp >> 6), K_BYTE);
              put_result(1, CONT | {2'b00, cp[5:0] & CONT_MASK}, K_BYTE);
              n = 2;
            end else if (cp >= SURR_LO && cp <= SURR_HI) begin
              n = drop_string(K_MALF);
            end else begin
              dec_phase = PH_BODY;
              put_result(0, LEAD3 | 8'(cp >> 12), K_BYTE);
              put_result(1, CONT | {2'b00, cp[11:6] & CONT_MASK}, K_BYTE);
              put_result(2, CONT | {2'b00, cp[5:0] & CONT_MASK}, K_BYTE);
              n = 3;
            end
          end
        end
      end
    endcase
    if (n > 0) step_res[n - 1].last = 1'b1;
    return n;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // results checked against the oldest pending one, accepted requests predicted
  always @(posedge clk) begin
    int      n;
    result_t exp_r;
    if (!rst) begin
      if (result.valid && result.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %0h kind %0d last %0b",
                   $time, result.out_byte, result.kind, result.last);
          err_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("out_byte", exp_r.out_byte, result.out_byte);
          check_field("kind", exp_r.kind, result.kind);
          check_field("last", exp_r.last, result.last);
        end
      end
      if (feed.valid && feed.ready) begin
        n = unescape_byte(feed.in_byte);
        if (offer.fixed_n == BY_MODEL) begin
          for (int k = 0; k < n; k++) pending_results.push_back(step_res[k]);
        end else if (offer.fixed_n == 1) begin
          pending_results.push_back('{out_byte: offer.out_byte, kind: offer.kind, last: 1'b1});
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left = HOLD_CYCLES;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic send_row(input src_row_t row);
    while ($urandom_range(99) < src_idle_pct) begin
      feed.valid <= 1'b0;
      @(posedge clk);
    end
    feed.valid   <= 1'b1;
    feed.in_byte <= row.in_byte;
    offer        <= row;
    @(posedge clk);
    while (!feed.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_src(input logic [7:0] b);
    send_row('{b, BY_MODEL, K_BYTE, 8'h00});
  endtask

  task automatic wait_drain();
    feed.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + 8'(nib);
    return ($urandom_range(1) ? "A" : "a") + 8'(nib - 4'd10);
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    return c == CH_QUOTE || c == CH_BSL || c == CH_SLASH || c == CH_B || c == CH_F ||
           c == CH_N || c == CH_R || c == CH_T || c == CH_U;
  endfunction

  // one quoted string, mostly well formed, sometimes broken part way
  task automatic send_string();
    logic [7:0]  escapes [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    logic [7:0]  b;
    logic [15:0] cp;
    int          r;
    int          sel;
    int          good;
    strings_sent++;
    // stray bytes before the opening quote
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
        send_src(b);
      end
    end
    send_src(CH_QUOTE);
    repeat ($urandom_range(0, 8)) begin
      r = $urandom_range(99);
      if (r < 45) begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSL);
        send_src(b);
      end else if (r < 65) begin
        send_src(CH_BSL);
        send_src(escapes[$urandom_range(7)]);
      end else if (r < 92) begin
        sel = $urandom_range(19);
        if (sel < 6) cp = 16'($urandom_range(0, 16'h007F));
        else if (sel < 12) cp = 16'($urandom_range(16'h0080, 16'h07FF));
        else if (sel < 19) cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        else cp = 16'($urandom_range(SURR_LO, SURR_HI));
        send_src(CH_BSL);
        send_src(CH_U);
        for (int k = 3; k >= 0; k--) send_src(hex_char(cp[k*4 +: 4]));
        if (cp >= SURR_LO && cp <= SURR_HI) return;
      end else begin
        sel = $urandom_range(2);
        if (sel == 0) begin
          send_src(CH_NUL);
        end else if (sel == 1) begin
          send_src(CH_BSL);
          do b = 8'($urandom_range(255)); while (is_escape_letter(b));
          send_src(b);
        end else begin
          send_src(CH_BSL);
          send_src(CH_U);
          good = $urandom_range(3);
          repeat (good) send_src(hex_char(4'($urandom_range(15))));
          do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0);
          send_src(b);
        end
        return;
      end
    end
    send_src(CH_QUOTE);
  endtask

  // stimulus
  initial begin
    int idle_modes [4][2] = '{'{0, 0}, '{63, 0}, '{0, 63}, '{26, 26}};
    int target;
    rst          <= 1'b1;
    feed.valid   <= 1'b0;
    feed.in_byte <= 8'h00;
    offer        <= '{8'h00, BY_MODEL, K_BYTE, 8'h00};
    dec_phase    = PH_WAIT;
    dec_code     = '0;
    dec_hex      = '0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_pending = 1'b0;
    err_cnt      = 0;
    bytes_sent   = 0;
    strings_sent = 0;
    results_seen = 0;
    cycle_cnt    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_row(directed_rows[i]);
    wait_drain();

    // random strings under each idling mix, draining between mixes
    for (int m = 0; m < 4; m++) begin
      src_idle_pct  = idle_modes[m][0];
      snk_stall_pct = idle_modes[m][1];
      if (m == 0) hold_pending = 1'b1;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_string();
      wait_drain();
    end

    $display("run covered %0d source bytes in %0d random strings plus directed rows,",
             bytes_sent, strings_sent);
    $display("with %0d results checked under four idling mixes", results_seen);
    if (err_cnt == 0) begin
      $display("[json_string_unescape_top] OK");
    end else begin
      $display("[json_string_unescape_top] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/jsu_pkg.sv
rtl/jsu_feed_if.sv
rtl/jsu_result_if.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_top.sv
tb/tb.sv
